// ===== sv/bhep_pkg.sv =====
// Package for the bi-histogram equaliser with plateau limit.
// Holds the controller state type and the fixed gray-level constants.
// No dependencies.
package bhep_pkg;

  localparam int NUM_BINS = 256;
  localparam logic [7:0] SPLIT_RESET = 8'd127;
  localparam logic [7:0] SPLIT_MAX = 8'd254;
  localparam logic [7:0] PIX_MAX = 8'd255;

  // Controller states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_BIN_UPD  = 12'b000000000010,
    ST_MAP_OUT  = 12'b000000000100,
    ST_SUM_RD   = 12'b000000001000,
    ST_SUM_ACC  = 12'b000000010000,
    ST_PLAT_DIV = 12'b000000100000,
    ST_CLIP_RD  = 12'b000001000000,
    ST_CLIP_ACC = 12'b000010000000,
    ST_PDF_RD   = 12'b000100000000,
    ST_PDF_ST   = 12'b001000000000,
    ST_PDF_DIV  = 12'b010000000000,
    ST_MAP_WR   = 12'b100000000000
  } bhep_state_t;

endpackage

// ===== sv/bhep_div.sv =====
// Restoring divider for the equaliser table build, one quotient bit per cycle.
// Used for the plateau and for each normalised pdf value. No dependencies.
module bhep_div #(
  parameter int DW = 37,
  parameter int VW = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [DW-1:0] quo_r;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register shifts the dividend out as quotient bits come in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/bi_histogram_equalizer_plateau.sv =====
// Top level of the bi-histogram equaliser with plateau limit.
// Depends on bhep_pkg and on the divider bhep_div.
//
//  Channel   Ports                                          Direction
//  in        in_valid, in_stall, in_func, in_pixel, in_last  item in
//  out       out_valid, out_stall, out_mapped_pixel          item out
//  cfg       cfg_wr_en, cfg_wr_data (split level)            register write
//
// An accumulate or map item reads the bin or table memory, then does the
// write-back or the output register load.
// The accumulate item marked last then holds the input for the table build, in
// which the bit-serial divider runs once per half and once per bin whose half
// has a nonzero clipped sum.
// Reset is synchronous; both tables read as their reset values at once.
// A waiting result holds a following map item in its output step until the
// output side takes the result, and the input stalls meanwhile; accumulate items never wait on the result.
module bi_histogram_equalizer_plateau
  import bhep_pkg::*;
#(
  parameter int COUNT_BITS = 21,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_mapped_pixel,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int DW   = COUNT_BITS + FRAC_BITS;
  localparam int SUMW = COUNT_BITS + 8;
  localparam int CDFW = FRAC_BITS + 1;
  localparam int DTW  = FRAC_BITS + 2;
  localparam int PRW  = FRAC_BITS + 11;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  bhep_state_t state_r, state_nxt;

  logic [7:0]            split_r;
  logic [7:0]            s_r;
  logic [7:0]            pix_r;
  logic                  last_r;
  logic                  half_r;
  logic [7:0]            lo_r;
  logic [7:0]            hi_r;
  logic [7:0]            cur_r;
  logic [SUMW-1:0]       raw_r;
  logic [COUNT_BITS-1:0] plat_r;
  logic [SUMW-1:0]       clip_r;
  logic [CDFW-1:0]       cdf_r;
  logic [CDFW-1:0]       pdf_r;
  logic                  out_vld_r;
  logic [7:0]            out_pix_r;
  logic                  out_load;

  // Bin memory and its valid bits.
  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_vld_r;
  logic [7:0]            bin_ra;
  logic [COUNT_BITS-1:0] bin_rd_r;
  logic                  bin_rv_r;
  logic                  bin_we;
  logic [COUNT_BITS-1:0] bin_val;
  logic [COUNT_BITS-1:0] bin_inc;

  // Transfer table memory and its valid bits.
  logic [7:0]          tab_mem [NUM_BINS];
  logic [NUM_BINS-1:0] tab_vld_r;
  logic [7:0]          tab_rd_r;
  logic [7:0]          tab_ra_r;
  logic                tab_rv_r;
  logic                tab_we;
  logic [7:0]          tab_val;

  logic                  in_acc;
  logic [SUMW-1:0]       raw_sum;
  logic [COUNT_BITS-1:0] c_val;
  logic [8:0]            n_bins;
  logic                  at_hi;
  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic [SUMW-1:0]       div_divisor;
  logic                  div_done;
  logic [DW-1:0]         div_q;
  logic [CDFW-1:0]       cdf_sum;
  logic [DTW-1:0]        d_val;
  logic [8:0]            scale;
  logic [PRW-1:0]        prod;
  logic [9:0]            prod_hi;
  logic [8:0]            base;
  logic [10:0]           map_sum;
  logic [7:0]            map_val;
  logic [7:0]            s_clamped;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;
  assign at_hi    = cur_r == hi_r;
  // The output register is loaded once it is empty or being emptied.
  assign out_load = (state_r == ST_MAP_OUT) && !(out_vld_r && out_stall);

  // Memory read and write-back.
  assign bin_ra  = (state_r == ST_IDLE) ? in_pixel : cur_r;
  assign bin_val = bin_rv_r ? bin_rd_r : '0;
  assign bin_inc = (bin_val == CNT_MAX) ? bin_val : bin_val + 1'b1;
  assign bin_we  = state_r == ST_BIN_UPD;
  assign tab_val = tab_rv_r ? tab_rd_r : tab_ra_r;
  assign tab_we  = state_r == ST_MAP_WR;

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[pix_r] <= bin_inc;
    end
    bin_rd_r <= bin_mem[bin_ra];
  end

  // The table read is held while a map item waits for the output register.
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[cur_r] <= map_val;
    end
    if (state_r == ST_IDLE) begin
      tab_rd_r <= tab_mem[in_pixel];
      tab_ra_r <= in_pixel;
    end
  end

  // Valid bits: a bin not valid reads zero, a table entry not valid reads identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      tab_vld_r <= '0;
      bin_rv_r  <= 1'b0;
      tab_rv_r  <= 1'b0;
    end else begin
      bin_rv_r <= bin_vld_r[bin_ra];
      if (state_r == ST_IDLE) begin
        tab_rv_r <= tab_vld_r[in_pixel];
      end
      if (bin_we) begin
        bin_vld_r[pix_r] <= 1'b1;
      end
      if (tab_we) begin
        tab_vld_r[cur_r] <= 1'b1;
        if (at_hi && half_r) begin
          bin_vld_r <= '0;
        end
      end
    end
  end

  // Half statistics and divider operands.
  assign raw_sum   = raw_r + SUMW'(bin_val);
  assign c_val     = (bin_val > plat_r) ? plat_r : bin_val;
  assign n_bins    = 9'(hi_r) - 9'(lo_r) + 9'd1;
  assign div_start = ((state_r == ST_SUM_ACC) && at_hi)
                  || ((state_r == ST_PDF_ST) && (clip_r != '0));
  assign div_dividend = (state_r == ST_SUM_ACC) ? DW'(raw_sum)
                                                : {c_val, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (state_r == ST_SUM_ACC) ? SUMW'(n_bins) : clip_r;
  assign s_clamped    = (split_r > SPLIT_MAX) ? SPLIT_MAX : split_r;

  bhep_div #(
    .DW(DW),
    .VW(SUMW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  // Map entry: base plus the scaled midpoint of the cdf step, saturated.
  assign cdf_sum = cdf_r + pdf_r;
  assign d_val   = {cdf_sum, 1'b0} - DTW'(pdf_r);
  assign scale   = half_r ? (9'd256 - 9'(s_r)) : 9'(s_r);
  assign prod    = PRW'(scale) * PRW'(d_val);
  assign prod_hi = prod[PRW-1:FRAC_BITS+1];
  assign base    = half_r ? (9'(s_r) + 9'd1) : 9'd0;
  assign map_sum = 11'(base) + 11'(prod_hi);
  assign map_val = (map_sum > 11'(PIX_MAX)) ? PIX_MAX : map_sum[7:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_func ? ST_MAP_OUT : ST_BIN_UPD;
        end
      end
      ST_BIN_UPD:  state_nxt = last_r ? ST_SUM_RD : ST_IDLE;
      ST_MAP_OUT:  state_nxt = out_load ? ST_IDLE : ST_MAP_OUT;
      ST_SUM_RD:   state_nxt = ST_SUM_ACC;
      ST_SUM_ACC:  state_nxt = at_hi ? ST_PLAT_DIV : ST_SUM_RD;
      ST_PLAT_DIV: state_nxt = div_done ? ST_CLIP_RD : ST_PLAT_DIV;
      ST_CLIP_RD:  state_nxt = ST_CLIP_ACC;
      ST_CLIP_ACC: state_nxt = at_hi ? ST_PDF_RD : ST_CLIP_RD;
      ST_PDF_RD:   state_nxt = ST_PDF_ST;
      ST_PDF_ST:   state_nxt = (clip_r != '0) ? ST_PDF_DIV : ST_MAP_WR;
      ST_PDF_DIV:  state_nxt = div_done ? ST_MAP_WR : ST_PDF_DIV;
      ST_MAP_WR: begin
        if (!at_hi) begin
          state_nxt = ST_PDF_RD;
        end else if (!half_r) begin
          state_nxt = ST_SUM_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      split_r   <= SPLIT_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        split_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Build datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r  <= in_pixel;
      last_r <= in_last;
    end
    case (state_r)
      ST_BIN_UPD: begin
        s_r    <= s_clamped;
        half_r <= 1'b0;
        lo_r   <= '0;
        hi_r   <= s_clamped;
        cur_r  <= '0;
        raw_r  <= '0;
      end
      ST_MAP_OUT: begin
        if (out_load) begin
          out_pix_r <= tab_val;
        end
      end
      ST_SUM_ACC: begin
        raw_r <= raw_sum;
        if (!at_hi) begin
          cur_r <= cur_r + 1'b1;
        end
      end
      ST_PLAT_DIV: begin
        plat_r <= div_q[COUNT_BITS-1:0];
        cur_r  <= lo_r;
        clip_r <= '0;
      end
      ST_CLIP_ACC: begin
        clip_r <= clip_r + SUMW'(c_val);
        cdf_r  <= '0;
        cur_r  <= at_hi ? lo_r : cur_r + 1'b1;
      end
      ST_PDF_ST:  pdf_r <= '0;
      ST_PDF_DIV: pdf_r <= div_q[FRAC_BITS:0];
      ST_MAP_WR: begin
        cdf_r <= cdf_sum;
        if (!at_hi) begin
          cur_r <= cur_r + 1'b1;
        end else if (!half_r) begin
          half_r <= 1'b1;
          lo_r   <= s_r + 1'b1;
          hi_r   <= PIX_MAX;
          cur_r  <= s_r + 1'b1;
          raw_r  <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_vld_r;
  assign out_mapped_pixel = out_pix_r;

endmodule

// ===== sv/bhep_checker.sv =====
// Port-level checks for the bi-histogram equaliser with plateau limit.
// Bound to the top level; no package needed.
module bhep_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_mapped_pixel
);

  // A result waiting on a stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mapped_pixel))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one still in work");

  // An accumulate item raises no result from its write-back step.
  a_acc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_func |=> ##1 !$rose(out_valid))
    else $error("accumulate item produced a result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bi_histogram_equalizer_plateau bhep_checker u_bhep_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_mapped_pixel(out_mapped_pixel)
);

// ===== sim/bhep_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bi-histogram equaliser: watches the item channels and the
// split-level write, predicts every mapped pixel and compares it on arrival.
// Depends on bhep_pkg for the gray-level constants.
module bhep_scoreboard
  import bhep_pkg::*;
#(
  parameter int COUNT_BITS = 21,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_mapped_pixel,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fails,
  output int         pending
);

  logic [7:0]  split_q;
  longint      hist [NUM_BINS];
  logic [7:0]  eq_map [NUM_BINS];
  logic [7:0]  mapped_due [$];

  // Rebuilds the transfer map from the histogram, then clears the histogram.
  task automatic rebuild_map();
    longint clipped_bin [NUM_BINS];
    longint raw, plat, clip_sum, pdf, cdf, d, v;
    int s, lo, hi;
    s = int'((split_q > SPLIT_MAX) ? SPLIT_MAX : split_q);
    for (int h = 0; h < 2; h++) begin
      lo = h ? s + 1 : 0;
      hi = h ? 255 : s;
      raw = 0;
      clip_sum = 0;
      cdf = 0;
      for (int i = lo; i <= hi; i++) raw += hist[i];
      plat = raw / (hi - lo + 1);
      for (int i = lo; i <= hi; i++) begin
        clipped_bin[i] = (hist[i] > plat) ? plat : hist[i];
        clip_sum += clipped_bin[i];
      end
      for (int i = lo; i <= hi; i++) begin
        pdf = (clip_sum != 0) ? (clipped_bin[i] << FRAC_BITS) / clip_sum : 0;
        cdf += pdf;
        d = 2 * cdf - pdf;
        if (h) v = (s + 1) + (((256 - s) * d) >> (FRAC_BITS + 1));
        else v = (s * d) >> (FRAC_BITS + 1);
        eq_map[i] = (v > PIX_MAX) ? PIX_MAX : v[7:0];
      end
    end
    for (int i = 0; i < NUM_BINS; i++) hist[i] = 0;
  endtask

  // Predicts on accepted items and compares each mapped pixel in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      split_q = SPLIT_RESET;
      for (int i = 0; i < NUM_BINS; i++) begin
        hist[i] = 0;
        eq_map[i] = i[7:0];
      end
      mapped_due.delete();
      fails = 0;
    end else begin
      if (cfg_wr_en) split_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_func) begin
          mapped_due.push_back(eq_map[in_pixel]);
        end else begin
          if (hist[in_pixel] < (64'd1 << COUNT_BITS) - 1) hist[in_pixel]++;
          if (in_last) rebuild_map();
        end
      end
      if (out_valid && !out_stall) begin
        if (mapped_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected mapped pixel %0d", out_mapped_pixel);
        end else if (mapped_due[0] !== out_mapped_pixel) begin
          fails++;
          if (fails <= 10)
            $display("mapped pixel: expected %0d, got %0d", mapped_due[0], out_mapped_pixel);
          void'(mapped_due.pop_front());
        end else begin
          void'(mapped_due.pop_front());
        end
      end
    end
    pending = mapped_due.size();
  end

  final begin
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the bi-histogram equaliser: drives regions of pixels and
// map lookups under several split levels and gives the verdict.
// Depends on bhep_pkg, the block and bhep_scoreboard.
module tb
  import bhep_pkg::*;
;

  localparam int BUILD_WAIT = 15000;
  localparam int STALL_LIMIT = 60000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_func = 1'b0;
  logic [7:0] in_pixel = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_mapped_pixel;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  int         fails, pending;
  int         gap_in = 0, gap_out = 0;
  int         quiet_cycles = 0;
  int         n_items = 0;
  int         cur_split = int'(SPLIT_RESET);

  always #5 clk = ~clk;

  bi_histogram_equalizer_plateau u_top (.*);

  bhep_scoreboard u_chk (.*);

  // The receiver stalls at random at the current rate.
  always @(posedge clk) out_stall <= ($urandom_range(99) < gap_out);

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one item and waits until it is taken.
  task automatic send(input logic func, input logic [7:0] pix, input logic last);
    while ($urandom_range(99) < gap_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_pixel <= pix;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  // Waits for every result and for a build to finish, then writes the split.
  task automatic write_split(input logic [7:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (BUILD_WAIT) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_split = int'((val > SPLIT_MAX) ? SPLIT_MAX : val);
  endtask

  // Picks a pixel from one of several distributions.
  function automatic logic [7:0] pick_pixel(input int shape, input int centre);
    case (shape)
      0: return 8'($urandom_range(cur_split, 0));
      1: return 8'($urandom_range(255, cur_split + 1));
      2: return 8'(centre + $urandom_range(6));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One region of accumulated pixels closed by last, then lookups.
  task automatic region();
    int len, shape, centre;
    len = ($urandom_range(9) < 7) ? $urandom_range(40, 1) : $urandom_range(200, 41);
    shape = $urandom_range(4);
    centre = $urandom_range(255);
    for (int i = 0; i < len; i++) send(1'b0, pick_pixel(shape, centre), i == len - 1);
    repeat ($urandom_range(60, 20))
      send(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity lookups, a single-pixel region leaving one half empty,
    // a region over both halves, last ignored on a lookup, and the extreme gray levels.
    send(1'b1, 8'd0, 1'b0);
    send(1'b1, 8'd255, 1'b1);
    send(1'b0, 8'd0, 1'b1);
    send(1'b1, 8'd0, 1'b0);
    send(1'b1, 8'd127, 1'b0);
    send(1'b1, 8'd128, 1'b0);
    send(1'b1, 8'd255, 1'b0);
    send(1'b0, 8'd255, 1'b0);
    send(1'b0, 8'd255, 1'b0);
    send(1'b0, 8'd0, 1'b0);
    send(1'b0, 8'd127, 1'b0);
    send(1'b0, 8'd128, 1'b1);
    send(1'b1, 8'd0, 1'b1);
    send(1'b1, 8'd127, 1'b0);
    send(1'b1, 8'd128, 1'b0);
    send(1'b1, 8'd255, 1'b0);

    // Random phases: split level and idling rates change between phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_split(8'd0);
        1: write_split(8'd255);
        2: write_split(8'($urandom_range(254)));
        default: write_split(8'd254);
      endcase
      gap_in = (p == 0) ? 30 : (p == 1) ? 75 : 0;
      gap_out = (p == 0) ? 75 : (p == 1) ? 30 : 0;
      send(1'b1, 8'd0, 1'b0);
      send(1'b1, 8'd255, 1'b0);
      while (n_items < 16 + (p + 1) * 435) region();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
